>>> design/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/psa_pkg.sv
// Package for the presence state arbiter: item types, state codes, register map
package psa_pkg;

    localparam int unsigned TIME_W  = 63;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned LIMIT_W = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned CFG_IDX_W = 3;

    // Occupancy state codes
    typedef enum logic [2:0] {
        ST_INIT      = 3'd0,
        ST_CALIB     = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_MOTION    = 3'd3,
        ST_PRESENT   = 3'd4,
        ST_UNCERTAIN = 3'd5,
        ST_DEGRADED  = 3'd6
    } state_t;

    // Operation codes
    localparam logic FUNC_UPDATE  = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_ENTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_EXIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_ENTER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_EXIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HEALTH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_LIMIT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_DWELL   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_DWELL    = 3'd7;

    // Register reset values
    localparam logic [LEVEL_W-1:0] RST_MOTION_ENTER   = 16'd39322;
    localparam logic [LEVEL_W-1:0] RST_MOTION_EXIT    = 16'd26214;
    localparam logic [LEVEL_W-1:0] RST_PRESENCE_ENTER = 16'd32768;
    localparam logic [LEVEL_W-1:0] RST_PRESENCE_EXIT  = 16'd19661;
    localparam logic [LEVEL_W-1:0] RST_MIN_HEALTH     = 16'd32768;
    localparam logic [LIMIT_W-1:0] RST_MEMORY_LIMIT   = 32'd300000000;
    localparam logic [LIMIT_W-1:0] RST_MOTION_DWELL   = 32'd500000;
    localparam logic [LIMIT_W-1:0] RST_EMPTY_DWELL    = 32'd10000000;

    typedef struct packed {
        logic               func;
        logic [TIME_W-1:0]  now_time_us;
        logic               relocated;
        logic               calibration_ok;
        logic [LEVEL_W-1:0] link_health;
        logic               health_finite;
        logic               data_gap;
        logic               baseline_ok;
        logic [LEVEL_W-1:0] motion_level;
        logic [LEVEL_W-1:0] presence_level;
        logic               method_conflict;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        current_code;
        logic [2:0]        candidate_code;
        logic [TIME_W-1:0] current_since_us;
        logic [TIME_W-1:0] candidate_since_out_us;
        logic              occupied_memory;
    } out_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] motion_enter_level;
        logic [LEVEL_W-1:0] motion_exit_level;
        logic [LEVEL_W-1:0] presence_enter_level;
        logic [LEVEL_W-1:0] presence_exit_level;
        logic [LEVEL_W-1:0] health_floor;
        logic [LIMIT_W-1:0] memory_limit_us;
        logic [LIMIT_W-1:0] motion_dwell_us;
        logic [LIMIT_W-1:0] empty_dwell_us;
    } cfg_t;

endpackage

>>> design/psa_cfg_regs.sv
// Configuration register file of the presence state arbiter
module psa_cfg_regs
    import psa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MOTION_ENTER:   cfg_next.motion_enter_level   = cfg_data[LEVEL_W-1:0];
                REG_MOTION_EXIT:    cfg_next.motion_exit_level    = cfg_data[LEVEL_W-1:0];
                REG_PRESENCE_ENTER: cfg_next.presence_enter_level = cfg_data[LEVEL_W-1:0];
                REG_PRESENCE_EXIT:  cfg_next.presence_exit_level  = cfg_data[LEVEL_W-1:0];
                REG_MIN_HEALTH:     cfg_next.health_floor         = cfg_data[LEVEL_W-1:0];
                REG_MEMORY_LIMIT:   cfg_next.memory_limit_us      = cfg_data[LIMIT_W-1:0];
                REG_MOTION_DWELL:   cfg_next.motion_dwell_us      = cfg_data[LIMIT_W-1:0];
                REG_EMPTY_DWELL:    cfg_next.empty_dwell_us       = cfg_data[LIMIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.motion_enter_level   <= RST_MOTION_ENTER;
            cfg_reg.motion_exit_level    <= RST_MOTION_EXIT;
            cfg_reg.presence_enter_level <= RST_PRESENCE_ENTER;
            cfg_reg.presence_exit_level  <= RST_PRESENCE_EXIT;
            cfg_reg.health_floor         <= RST_MIN_HEALTH;
            cfg_reg.memory_limit_us      <= RST_MEMORY_LIMIT;
            cfg_reg.motion_dwell_us      <= RST_MOTION_DWELL;
            cfg_reg.empty_dwell_us       <= RST_EMPTY_DWELL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/psa_core.sv
// Occupancy state registers and the single-pass update for one item
module psa_core
    import psa_pkg::*;
#(
    parameter logic [LIMIT_W-1:0] MOTION_EXIT_DWELL_US = 32'd2000000,
    parameter logic [LIMIT_W-1:0] PRESENCE_DWELL_US    = 32'd1000000,
    parameter logic [LIMIT_W-1:0] UNCERTAIN_DWELL_US   = 32'd3000000
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    state_t            cur_reg, cur_next;
    state_t            cand_reg, cand_next;
    logic [TIME_W-1:0] cur_time_reg, cur_time_next;
    logic [TIME_W-1:0] cand_time_reg, cand_time_next;
    logic [TIME_W-1:0] report_time_reg, report_time_next;
    logic [TIME_W-1:0] evid_time_reg, evid_time_next;
    logic              occ_reg, occ_next;

    logic [TIME_W-1:0]  now;
    logic               stale;
    logic               evid_hit;
    logic [TIME_W-1:0]  evid_diff, evid_age;
    logic [TIME_W-1:0]  cand_diff, cand_age;
    logic               expired;
    logic [LEVEL_W-1:0] mot_thr, pres_thr;
    state_t             req;
    logic               req_expire;
    logic [LIMIT_W-1:0] dwell;
    logic               to_calib, to_degraded;

    assign now = item.now_time_us;

    // Age of evidence and of the candidate, clamped at zero
    always_comb
    begin
        evid_diff = now - evid_time_reg;
        evid_age  = (now >= evid_time_reg) ? evid_diff : '0;
        cand_diff = now - cand_time_reg;
        cand_age  = (now >= cand_time_reg) ? cand_diff : '0;
    end

    // Fresh evidence restarts the memory, so it cannot expire in the same item
    assign evid_hit = (item.motion_level >= cfg.motion_enter_level)
                   || (item.presence_level >= cfg.presence_enter_level);
    assign expired  = occ_reg && !evid_hit && (evid_time_reg != '0)
                   && (evid_age > {{(TIME_W-LIMIT_W){1'b0}}, cfg.memory_limit_us});
    assign stale    = (report_time_reg != '0) && (now <= report_time_reg);

    assign to_calib    = item.relocated || !item.calibration_ok;
    assign to_degraded = !item.baseline_ok || !item.health_finite
                      || (item.link_health < cfg.health_floor) || item.data_gap;

    // Pick the requested state with hysteresis on both levels
    always_comb
    begin
        mot_thr    = (cur_reg == ST_MOTION) ? cfg.motion_exit_level : cfg.motion_enter_level;
        pres_thr   = (cur_reg == ST_PRESENT) ? cfg.presence_exit_level
                                             : cfg.presence_enter_level;
        req_expire = 1'b0;
        if (item.method_conflict)
            req = ST_UNCERTAIN;
        else if (item.motion_level >= mot_thr)
            req = ST_MOTION;
        else if (cur_reg == ST_MOTION && occ_reg)
            req = ST_PRESENT;
        else if (item.presence_level >= pres_thr)
            req = ST_PRESENT;
        else if (expired)
        begin
            req        = ST_UNCERTAIN;
            req_expire = 1'b1;
        end
        else
            req = ST_EMPTY;
    end

    // Dwell time of the requested state
    always_comb
    begin
        case (req)
            ST_MOTION:    dwell = cfg.motion_dwell_us;
            ST_PRESENT:   dwell = (cur_reg == ST_MOTION) ? MOTION_EXIT_DWELL_US
                                                         : PRESENCE_DWELL_US;
            ST_EMPTY:     dwell = cfg.empty_dwell_us;
            ST_UNCERTAIN: dwell = UNCERTAIN_DWELL_US;
            default:      dwell = '0;
        endcase
    end

    // Advance the state for one item
    always_comb
    begin
        cur_next         = cur_reg;
        cand_next        = cand_reg;
        cur_time_next    = cur_time_reg;
        cand_time_next   = cand_time_reg;
        report_time_next = report_time_reg;
        evid_time_next   = evid_time_reg;
        occ_next         = occ_reg;

        if (item.func == FUNC_RESTART)
        begin
            cur_next         = ST_INIT;
            cand_next        = ST_INIT;
            cur_time_next    = now;
            cand_time_next   = now;
            report_time_next = now;
            evid_time_next   = '0;
            occ_next         = 1'b0;
        end
        else if (!stale)
        begin
            report_time_next = now;
            if (to_calib)
            begin
                occ_next       = 1'b0;
                cur_next       = ST_CALIB;
                cand_next      = ST_CALIB;
                cur_time_next  = now;
                cand_time_next = now;
            end
            else if (to_degraded)
            begin
                cur_next       = ST_DEGRADED;
                cand_next      = ST_DEGRADED;
                cur_time_next  = now;
                cand_time_next = now;
            end
            else
            begin
                if (evid_hit)
                    evid_time_next = now;
                if (req_expire)
                    occ_next = 1'b0;
                if (req == cur_reg || req != cand_reg)
                begin
                    cand_next      = req;
                    cand_time_next = now;
                end
                else if (cand_age >= {{(TIME_W-LIMIT_W){1'b0}}, dwell})
                begin
                    cur_next       = req;
                    cand_next      = req;
                    cur_time_next  = now;
                    cand_time_next = now;
                    if (req == ST_MOTION || req == ST_PRESENT)
                    begin
                        occ_next       = 1'b1;
                        evid_time_next = now;
                    end
                    else if (req == ST_EMPTY)
                        occ_next = 1'b0;
                end
            end
        end
    end

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg         <= ST_INIT;
            cand_reg        <= ST_INIT;
            cur_time_reg    <= '0;
            cand_time_reg   <= '0;
            report_time_reg <= '0;
            evid_time_reg   <= '0;
            occ_reg         <= 1'b0;
        end
        else if (step)
        begin
            cur_reg         <= cur_next;
            cand_reg        <= cand_next;
            cur_time_reg    <= cur_time_next;
            cand_time_reg   <= cand_time_next;
            report_time_reg <= report_time_next;
            evid_time_reg   <= evid_time_next;
            occ_reg         <= occ_next;
        end
    end

    // Snapshot after the update
    always_comb
    begin
        result.current_code           = cur_next;
        result.candidate_code         = cand_next;
        result.current_since_us       = cur_time_next;
        result.candidate_since_out_us = cand_time_next;
        result.occupied_memory        = occ_next;
    end

endmodule

>>> design/presence_state_arbiter.sv
// Stages: two register stages, the input register and then the result register, which drives out_valid.
// Throughput: one item per cycle while out_stall is low; the state update is one pass of compare and subtract logic.
// The input register takes one further item while a result waits; the next one is stalled.
// Reset: asynchronous, active low; clears state and valid flags, sets config registers to defaults.
// Items stay in order; a stalled result holds until taken.
module presence_state_arbiter
    import psa_pkg::*;
#(
    parameter logic [31:0] MOTION_EXIT_DWELL_US = 32'd2000000,
    parameter logic [31:0] PRESENCE_DWELL_US    = 32'd1000000,
    parameter logic [31:0] UNCERTAIN_DWELL_US   = 32'd3000000
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;
    logic      step;
    cfg_t      cfg;
    out_item_t result;

    psa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    psa_core #(
        .MOTION_EXIT_DWELL_US (MOTION_EXIT_DWELL_US),
        .PRESENCE_DWELL_US    (PRESENCE_DWELL_US),
        .UNCERTAIN_DWELL_US   (UNCERTAIN_DWELL_US)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Result register can take a new item when empty or being drained
    assign advance  = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_item_reg <= in_data;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_item_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

>>> design/psa_checker.sv
// Port-level checker for the presence state arbiter, bound to the top level
`include "assert_macros.svh"

module psa_checker
    import psa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input out_item_t out_data,
    input logic      out_valid,
    input logic      out_stall
);

    logic held;
    logic occ_bad;
    logic cand_early;

    // A result offered under stall
    assign held = out_valid && out_stall;

    // Occupancy memory shown in calibration-required or initializing state
    assign occ_bad = out_valid && out_data.occupied_memory
                  && ((out_data.current_code == ST_CALIB) || (out_data.current_code == ST_INIT));

    // Candidate time stamp earlier than that of the current state
    assign cand_early = out_valid
                     && (out_data.candidate_since_out_us < out_data.current_since_us);

    // A stalled result holds
    `ASSERT_CLK(a_out_hold, clk, rst_n, held |=> out_valid && $stable(out_data), "held result moved")

    // An empty result register never back-pressures the input
    `ASSERT_ALWAYS(a_no_stall_empty, clk, !out_valid |-> !in_stall, "input stalled with no result")

    // Calibration-required and initializing states never hold occupancy memory
    `ASSERT_CLK(a_occ_clear, clk, rst_n, !occ_bad, "occupancy held in calib or init")

    // The candidate is never older than the current state
    `ASSERT_CLK(a_cand_time, clk, rst_n, !cand_early, "candidate older than current state")

endmodule

bind presence_state_arbiter psa_checker u_psa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
);

>>> test/psa_check_pkg.sv
// Occupancy predictor and result checker used by the presence state arbiter testbench
`timescale 1ns / 100ps
package psa_check_pkg;
    import psa_pkg::*;

    // Dwell times built into the block, passed to it as parameters
    localparam logic [31:0] EXIT_DWELL_US      = 32'd2000000;
    localparam logic [31:0] PRESENCE_DWELL_US  = 32'd1000000;
    localparam logic [31:0] UNCERTAIN_DWELL_US = 32'd3000000;

    class occupancy_checker;
        cfg_t              regs;
        state_t            cur_state;
        state_t            cand_state;
        logic [TIME_W-1:0] cur_since;
        logic [TIME_W-1:0] cand_since;
        logic [TIME_W-1:0] last_report;
        logic [TIME_W-1:0] last_evidence;
        logic              occupied;
        out_item_t         expected_snapshots[$];
        int                mismatch_count;

        function new();
            regs.motion_enter_level   = RST_MOTION_ENTER;
            regs.motion_exit_level    = RST_MOTION_EXIT;
            regs.presence_enter_level = RST_PRESENCE_ENTER;
            regs.presence_exit_level  = RST_PRESENCE_EXIT;
            regs.health_floor         = RST_MIN_HEALTH;
            regs.memory_limit_us      = RST_MEMORY_LIMIT;
            regs.motion_dwell_us      = RST_MOTION_DWELL;
            regs.empty_dwell_us       = RST_EMPTY_DWELL;
            cur_state      = ST_INIT;
            cand_state     = ST_INIT;
            cur_since      = '0;
            cand_since     = '0;
            last_report    = '0;
            last_evidence  = '0;
            occupied       = 1'b0;
            mismatch_count = 0;
        endfunction

        function void write_register(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] value);
            case (idx)
                REG_MOTION_ENTER:   regs.motion_enter_level   = value[LEVEL_W-1:0];
                REG_MOTION_EXIT:    regs.motion_exit_level    = value[LEVEL_W-1:0];
                REG_PRESENCE_ENTER: regs.presence_enter_level = value[LEVEL_W-1:0];
                REG_PRESENCE_EXIT:  regs.presence_exit_level  = value[LEVEL_W-1:0];
                REG_MIN_HEALTH:     regs.health_floor         = value[LEVEL_W-1:0];
                REG_MEMORY_LIMIT:   regs.memory_limit_us      = value;
                REG_MOTION_DWELL:   regs.motion_dwell_us      = value;
                REG_EMPTY_DWELL:    regs.empty_dwell_us       = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_snapshots.size();
        endfunction

        // Time between two stamps, floored at zero
        function logic [TIME_W-1:0] age(input logic [TIME_W-1:0] now_t,
                                        input logic [TIME_W-1:0] since_t);
            return (now_t >= since_t) ? now_t - since_t : '0;
        endfunction

        function void adopt(input state_t s, input logic [TIME_W-1:0] now_t);
            cur_state  = s;
            cand_state = s;
            cur_since  = now_t;
            cand_since = now_t;
        endfunction

        // State asked for by the levels, with hysteresis on the current state
        function state_t requested_state(input logic [TIME_W-1:0] now_t,
                                         input logic [LEVEL_W-1:0] motion,
                                         input logic [LEVEL_W-1:0] presence,
                                         input logic disagree);
            logic [LEVEL_W-1:0] bar;
            if (disagree)
                return ST_UNCERTAIN;
            bar = (cur_state == ST_MOTION) ? regs.motion_exit_level : regs.motion_enter_level;
            if (motion >= bar)
                return ST_MOTION;
            if (cur_state == ST_MOTION && occupied)
                return ST_PRESENT;
            bar = (cur_state == ST_PRESENT) ? regs.presence_exit_level
                                            : regs.presence_enter_level;
            if (presence >= bar)
                return ST_PRESENT;
            // Expire the occupancy memory once evidence is too old
            if (occupied && last_evidence != '0 &&
                age(now_t, last_evidence) > TIME_W'(regs.memory_limit_us))
            begin
                occupied = 1'b0;
                return ST_UNCERTAIN;
            end
            return ST_EMPTY;
        endfunction

        function logic [TIME_W-1:0] dwell_of(input state_t req);
            case (req)
                ST_MOTION:    return TIME_W'(regs.motion_dwell_us);
                ST_PRESENT:   return (cur_state == ST_MOTION) ? TIME_W'(EXIT_DWELL_US)
                                                              : TIME_W'(PRESENCE_DWELL_US);
                ST_EMPTY:     return TIME_W'(regs.empty_dwell_us);
                ST_UNCERTAIN: return TIME_W'(UNCERTAIN_DWELL_US);
                default:      return '0;
            endcase
        endfunction

        // Advance the occupancy state for one accepted report and queue its snapshot
        function void note_report(input in_item_t it);
            logic [TIME_W-1:0] now_t;
            state_t            req;
            out_item_t         snap;
            now_t = it.now_time_us;
            if (it.func == FUNC_RESTART)
            begin
                adopt(ST_INIT, now_t);
                last_report   = now_t;
                last_evidence = '0;
                occupied      = 1'b0;
            end
            else if (!(last_report != '0 && now_t <= last_report))
            begin
                last_report = now_t;
                if (it.relocated || !it.calibration_ok)
                begin
                    occupied = 1'b0;
                    adopt(ST_CALIB, now_t);
                end
                else if (!it.baseline_ok || !it.health_finite || it.data_gap ||
                         it.link_health < regs.health_floor)
                begin
                    adopt(ST_DEGRADED, now_t);
                end
                else
                begin
                    if (it.motion_level >= regs.motion_enter_level ||
                        it.presence_level >= regs.presence_enter_level)
                        last_evidence = now_t;
                    req = requested_state(now_t, it.motion_level, it.presence_level,
                                          it.method_conflict);
                    if (req == cur_state || req != cand_state)
                    begin
                        cand_state = req;
                        cand_since = now_t;
                    end
                    else if (age(now_t, cand_since) >= dwell_of(req))
                    begin
                        adopt(req, now_t);
                        if (req == ST_MOTION || req == ST_PRESENT)
                        begin
                            occupied      = 1'b1;
                            last_evidence = now_t;
                        end
                        else if (req == ST_EMPTY)
                        begin
                            occupied = 1'b0;
                        end
                    end
                end
            end
            snap.current_code           = cur_state;
            snap.candidate_code         = cand_state;
            snap.current_since_us       = cur_since;
            snap.candidate_since_out_us = cand_since;
            snap.occupied_memory        = occupied;
            expected_snapshots.push_back(snap);
        endfunction

        task flag_mismatch(input string msg);
            if (mismatch_count < 100)
                $display("MISMATCH at %0t ns: %s", $time, msg);
            mismatch_count++;
        endtask

        task compare_field(input string name, input logic [63:0] got,
                           input logic [63:0] want);
            if (got !== want)
                flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // Compare one taken result with the oldest queued snapshot
        task check_snapshot(input out_item_t got);
            out_item_t want;
            if (expected_snapshots.size() == 0)
            begin
                flag_mismatch($sformatf("result with no report pending: %h", got));
                return;
            end
            want = expected_snapshots.pop_front();
            compare_field("current_code", 64'(got.current_code), 64'(want.current_code));
            compare_field("candidate_code", 64'(got.candidate_code),
                          64'(want.candidate_code));
            compare_field("current_since_us", 64'(got.current_since_us),
                          64'(want.current_since_us));
            compare_field("candidate_since_out_us", 64'(got.candidate_since_out_us),
                          64'(want.candidate_since_out_us));
            compare_field("occupied_memory", 64'(got.occupied_memory),
                          64'(want.occupied_memory));
        endtask
    endclass

endpackage

>>> test/tb_top.sv
// Top-level testbench for the presence state arbiter: stimulus, idling and end of run
`timescale 1ns / 100ps
module tb_top;
    import psa_pkg::*;
    import psa_check_pkg::*;

    localparam int HOLD_CYCLES = 80;

    typedef enum int {SCN_MOTION, SCN_PRESENCE, SCN_VACANT, SCN_NOISE, SCN_THRESHOLD}
        scenario_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    int                sender_idle_pct = 0;
    int                receiver_stall_pct = 0;
    int                hold_requests = 0;
    int                holds_served = 0;
    int                hold_left = 0;
    cfg_t              active_cfg;
    logic [TIME_W-1:0] stim_time = '0;
    scenario_t         scenario = SCN_NOISE;
    int                episode_left = 0;
    occupancy_checker  occ_chk;

    always #1 clk = ~clk;

    presence_state_arbiter #(
        .MOTION_EXIT_DWELL_US (EXIT_DWELL_US),
        .PRESENCE_DWELL_US    (PRESENCE_DWELL_US),
        .UNCERTAIN_DWELL_US   (UNCERTAIN_DWELL_US)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Drive the result stall: a long hold-off when asked, else random per phase
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // Check every result taken at the clock edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            occ_chk.check_snapshot(out_data);
    end

    function automatic in_item_t good_report(input logic [TIME_W-1:0] now_t,
                                             input logic [LEVEL_W-1:0] motion,
                                             input logic [LEVEL_W-1:0] presence);
        in_item_t it;
        it                = '0;
        it.func           = FUNC_UPDATE;
        it.now_time_us    = now_t;
        it.calibration_ok = 1'b1;
        it.link_health    = '1;
        it.health_finite  = 1'b1;
        it.baseline_ok    = 1'b1;
        it.motion_level   = motion;
        it.presence_level = presence;
        return it;
    endfunction

    function automatic logic [LEVEL_W-1:0] below(input logic [LEVEL_W-1:0] lim);
        return (lim == '0) ? '0 : LEVEL_W'($urandom_range(lim - 1));
    endfunction

    function automatic logic [LEVEL_W-1:0] near(input logic [LEVEL_W-1:0] lim);
        int v;
        v = int'(lim) + int'($urandom_range(8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return LEVEL_W'(v);
    endfunction

    // Offer one item, idling first at random, and hold it until taken
    task automatic send_report(input in_item_t it);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        occ_chk.note_report(it);
    endtask

    // Stop offering and wait until every queued snapshot has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (occ_chk.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        occ_chk.write_register(idx, value);
    endtask

    // Write all registers; level registers carry junk in their upper bits
    task automatic load_settings(input cfg_t s);
        write_reg(REG_MOTION_ENTER,   {16'($urandom), s.motion_enter_level});
        write_reg(REG_MOTION_EXIT,    {16'($urandom), s.motion_exit_level});
        write_reg(REG_PRESENCE_ENTER, {16'($urandom), s.presence_enter_level});
        write_reg(REG_PRESENCE_EXIT,  {16'($urandom), s.presence_exit_level});
        write_reg(REG_MIN_HEALTH,     {16'($urandom), s.health_floor});
        write_reg(REG_MEMORY_LIMIT,   s.memory_limit_us);
        write_reg(REG_MOTION_DWELL,   s.motion_dwell_us);
        write_reg(REG_EMPTY_DWELL,    s.empty_dwell_us);
        @(negedge clk);
        cfg_write <= 1'b0;
        active_cfg = s;
    endtask

    // Build the next report: episodes of one scenario so dwell times can run out
    task automatic next_random_report(output in_item_t it);
        int          sel;
        logic [63:0] wide;
        if (episode_left == 0)
        begin
            scenario     = scenario_t'($urandom_range(4));
            episode_left = $urandom_range(10, 3);
        end
        episode_left = episode_left - 1;
        it      = '0;
        it.func = ($urandom_range(99) < 3) ? FUNC_RESTART : FUNC_UPDATE;

        // Advance the report time; a few reports repeat or go back in time
        sel = $urandom_range(99);
        if (it.func == FUNC_RESTART && sel < 50)
        begin
            wide      = {$urandom, $urandom};
            stim_time = wide[TIME_W-1:0];
            if (&stim_time[TIME_W-1:40])
                stim_time[40] = 1'b0;
            it.now_time_us = stim_time;
        end
        else if (sel < 5)
        begin
            it.now_time_us = (stim_time > 1000) ? stim_time - TIME_W'($urandom_range(1000))
                                                : stim_time;
        end
        else
        begin
            if (sel < 7)
                stim_time += TIME_W'($urandom);
            else if (sel < 20)
                stim_time += TIME_W'($urandom_range(50000, 1));
            else if (sel < 90)
                stim_time += TIME_W'($urandom_range(1500000, 100000));
            else
                stim_time += TIME_W'($urandom_range(50000000, 2000000));
            it.now_time_us = stim_time;
        end

        // Occasional faults
        it.relocated       = ($urandom_range(99) < 3);
        it.calibration_ok  = ($urandom_range(99) >= 3);
        it.health_finite   = ($urandom_range(99) >= 3);
        it.data_gap        = ($urandom_range(99) < 3);
        it.baseline_ok     = ($urandom_range(99) >= 3);
        it.link_health     = ($urandom_range(99) < 90)
                             ? 16'($urandom_range(65535, active_cfg.health_floor))
                             : 16'($urandom);
        it.method_conflict = ($urandom_range(99) < 6);

        case (scenario)
            SCN_MOTION:
            begin
                it.motion_level   = 16'($urandom_range(65535, active_cfg.motion_exit_level));
                it.presence_level = 16'($urandom);
            end
            SCN_PRESENCE:
            begin
                it.motion_level   = below(active_cfg.motion_exit_level);
                it.presence_level = 16'($urandom_range(65535,
                                                       active_cfg.presence_exit_level));
            end
            SCN_VACANT:
            begin
                it.motion_level = below((active_cfg.motion_exit_level <
                                         active_cfg.motion_enter_level)
                                        ? active_cfg.motion_exit_level
                                        : active_cfg.motion_enter_level);
                it.presence_level = below((active_cfg.presence_exit_level <
                                           active_cfg.presence_enter_level)
                                          ? active_cfg.presence_exit_level
                                          : active_cfg.presence_enter_level);
            end
            SCN_NOISE:
            begin
                it.motion_level    = 16'($urandom);
                it.presence_level  = 16'($urandom);
                it.method_conflict = 1'($urandom_range(1));
            end
            default:
            begin
                it.motion_level   = near($urandom_range(1) ? active_cfg.motion_enter_level
                                                           : active_cfg.motion_exit_level);
                it.presence_level = near($urandom_range(1) ? active_cfg.presence_enter_level
                                                           : active_cfg.presence_exit_level);
            end
        endcase
    endtask

    // One settings phase; halfway through, pause until all results are back
    task automatic run_phase(input cfg_t s, input int idle_pct, input int stall_pct,
                             input bit long_hold, input int count);
        in_item_t it;
        drain();
        load_settings(s);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        if (long_hold)
            hold_requests++;
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                drain();
            next_random_report(it);
            send_report(it);
        end
    endtask

    initial
    begin
        in_item_t it;
        cfg_t     reset_cfg;
        cfg_t     s;
        occ_chk    = new();
        reset_cfg  = occ_chk.regs;
        active_cfg = reset_cfg;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the states at reset settings
        send_report(good_report(0, 0, 0));
        send_report(good_report(0, '1, 0));           // time zero again is still fresh
        send_report(good_report(600000, '1, 0));      // motion adopted
        send_report(good_report(600000, '1, 0));      // same stamp: ignored
        send_report(good_report(500000, 0, 0));       // older stamp: ignored
        send_report(good_report(700000, RST_MOTION_EXIT, 0));
        send_report(good_report(800000, RST_MOTION_EXIT - 16'd1, 0));
        send_report(good_report(2900000, 0, 0));      // present after motion exit dwell
        it = good_report(3000000, 0, 0);
        it.method_conflict = 1'b1;
        send_report(it);
        it.now_time_us = 6100000;
        send_report(it);                              // uncertain adopted
        it = good_report(6200000, 0, 0);
        it.health_finite = 1'b0;
        send_report(it);                              // non-finite health, full score
        it = good_report(6300000, 0, 0);
        it.link_health = RST_MIN_HEALTH - 16'd1;
        send_report(it);
        it = good_report(6400000, 0, 0);
        it.data_gap = 1'b1;
        send_report(it);
        it = good_report(6500000, 0, 0);
        it.baseline_ok = 1'b0;
        send_report(it);
        it = good_report(6600000, 0, 0);
        it.relocated = 1'b1;
        send_report(it);
        it = good_report(6700000, 0, 0);
        it.calibration_ok = 1'b0;
        send_report(it);
        send_report(good_report(6800000, 0, RST_PRESENCE_ENTER));
        send_report(good_report(7900000, 0, RST_PRESENCE_ENTER));
        send_report(good_report(407900000, 0, 0));    // memory expires
        it = '1;
        it.func = FUNC_RESTART;
        it.now_time_us = {TIME_W{1'b1}} - 1000;
        send_report(it);                              // restart ignores the other fields
        send_report(good_report({TIME_W{1'b1}} - 500, '1, '1));
        send_report(good_report({TIME_W{1'b1}}, '1, 0));
        it = '0;
        it.func = FUNC_RESTART;
        send_report(it);                              // restart at time zero
        send_report(good_report(0, 0, 0));
        send_report(good_report(10000000, 0, 0));     // empty adopted
        stim_time = 10000000;

        // Random phases over several settings, extremes among them
        run_phase(reset_cfg, 0, 0, 1'b0, 72);

        s = reset_cfg;
        s.motion_enter_level   = 16'($urandom);
        s.motion_exit_level    = 16'($urandom);
        s.presence_enter_level = 16'($urandom);
        s.presence_exit_level  = 16'($urandom);
        s.memory_limit_us      = '0;
        s.motion_dwell_us      = '0;
        s.empty_dwell_us       = '0;
        run_phase(s, 52, 0, 1'b1, 72);

        s = '1;
        s.health_floor = '0;
        run_phase(s, 0, 52, 1'b0, 72);

        s = '0;
        s.health_floor    = '1;
        s.memory_limit_us = 32'd5000000;
        s.motion_dwell_us = $urandom_range(1000000);
        s.empty_dwell_us  = $urandom_range(3000000);
        run_phase(s, 8, 8, 1'b0, 72);

        s.motion_enter_level   = 16'($urandom);
        s.motion_exit_level    = 16'($urandom);
        s.presence_enter_level = 16'($urandom);
        s.presence_exit_level  = 16'($urandom);
        s.health_floor         = 16'($urandom_range(40000));
        s.memory_limit_us      = $urandom_range(50000000, 1000000);
        s.motion_dwell_us      = $urandom_range(3000000);
        s.empty_dwell_us       = $urandom_range(3000000);
        run_phase(s, 0, 52, 1'b1, 72);

        s = reset_cfg;
        s.health_floor = 16'($urandom_range(40000));
        run_phase(s, 8, 8, 1'b0, 72);

        drain();
        repeat (10) @(posedge clk);
        if (occ_chk.mismatch_count == 0)
            $display("presence_state_arbiter verification clean");
        else
            $display("presence_state_arbiter verification failed");
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #400000;
        $display("presence_state_arbiter verification failed");
        $finish;
    end

endmodule
